/* sv/itlfa_pkg.sv */
// Shared types and constants for the lowest-free index allocator table.
package itlfa_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int IDX_W       = 7;
  localparam int HANDLE_W    = 16;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int DATA_W      = 24;

  typedef enum logic [OP_W-1:0] {
    OP_ADD       = 2'd0,
    OP_REMOVE    = 2'd1,
    OP_FIND      = 2'd2,
    OP_FIND_NEXT = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NULL      = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
    logic slot_free;
  } sts_t;

endpackage

/* sv/itlfa_datapath.sv */
// Datapath: used map, handle memory, scan pipeline and result register.
module itlfa_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  itlfa_pkg::cmd_t                    cmd,
  input  logic [itlfa_pkg::OP_W-1:0]         in_op,
  input  logic [itlfa_pkg::HANDLE_W-1:0]     in_handle,
  input  logic [itlfa_pkg::IDX_W-1:0]        in_index,
  input  logic                               m_tready,
  output itlfa_pkg::sts_t                    sts,
  output logic                               m_tvalid,
  output logic [itlfa_pkg::DATA_W-1:0]       m_tdata,   // found_index, found_handle
  output logic [itlfa_pkg::STATUS_W-1:0]     m_tuser    // status
);

  localparam logic [itlfa_pkg::IDX_W-1:0] DEPTH_IDX =
    itlfa_pkg::IDX_W'(itlfa_pkg::TABLE_DEPTH);

  itlfa_pkg::op_t                     op;
  logic [itlfa_pkg::HANDLE_W-1:0]     hnd;
  logic [itlfa_pkg::IDX_W-1:0]        lim;
  logic [itlfa_pkg::IDX_W-1:0]        cnt;
  logic                               bad;
  logic                               p_valid;
  logic [itlfa_pkg::ADDR_W-1:0]       p_idx;
  logic                               p_used;
  logic [itlfa_pkg::HANDLE_W-1:0]     rdata;
  logic [itlfa_pkg::TABLE_DEPTH-1:0]  used_map;
  logic [itlfa_pkg::HANDLE_W-1:0]     mem [itlfa_pkg::TABLE_DEPTH];

  logic                               out_valid;
  itlfa_pkg::status_t                 out_status;
  logic [itlfa_pkg::IDX_W-1:0]        out_index;
  logic [itlfa_pkg::HANDLE_W-1:0]     out_handle;

  logic [itlfa_pkg::IDX_W-1:0]        start_in;
  logic [itlfa_pkg::IDX_W-1:0]        lim_in;
  logic                               bad_in;
  logic                               issue;
  logic                               hit;
  logic                               done;
  itlfa_pkg::status_t                 res_status;
  logic [itlfa_pkg::IDX_W-1:0]        res_index;
  logic [itlfa_pkg::HANDLE_W-1:0]     res_handle;

  // Scan window and early rejection, worked out from the incoming request.
  always_comb begin
    start_in = '0;
    lim_in   = DEPTH_IDX;
    bad_in   = 1'b0;
    case (itlfa_pkg::op_t'(in_op))
      itlfa_pkg::OP_ADD, itlfa_pkg::OP_REMOVE: begin
        bad_in = (in_handle == '0);
      end
      itlfa_pkg::OP_FIND: begin
        bad_in   = (in_index == '0) || (in_index > DEPTH_IDX);
        start_in = in_index - 1'b1;
        lim_in   = in_index;
      end
      itlfa_pkg::OP_FIND_NEXT: begin
        bad_in   = (in_index > DEPTH_IDX);
        start_in = (in_index == '0) ? '0 : in_index - 1'b1;
      end
      default: begin
        bad_in = 1'b1;
      end
    endcase
  end

  assign issue = (cnt < lim);

  always_comb begin
    case (op)
      itlfa_pkg::OP_ADD:    hit = p_valid && !p_used;
      itlfa_pkg::OP_REMOVE: hit = p_valid && p_used && (rdata == hnd);
      default:              hit = p_valid && p_used;
    endcase
  end

  assign done          = bad || hit || (!p_valid && !issue);
  assign sts.done      = done;
  assign sts.slot_free = !out_valid || m_tready;

  always_comb begin
    res_status = itlfa_pkg::ST_NOT_FOUND;
    res_index  = '0;
    res_handle = '0;
    if (bad) begin
      if (op == itlfa_pkg::OP_ADD || op == itlfa_pkg::OP_REMOVE) begin
        res_status = itlfa_pkg::ST_NULL;
      end
    end else if (hit) begin
      res_status = itlfa_pkg::ST_DONE;
      res_index  = itlfa_pkg::IDX_W'(p_idx) + 1'b1;
      res_handle = (op == itlfa_pkg::OP_ADD || op == itlfa_pkg::OP_REMOVE) ? hnd : rdata;
    end else if (op == itlfa_pkg::OP_ADD) begin
      res_status = itlfa_pkg::ST_FULL;
    end
  end

  // Request registers and scan pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      cnt     <= '0;
      lim     <= '0;
      bad     <= 1'b0;
      op      <= itlfa_pkg::OP_ADD;
    end else if (cmd.load) begin
      op      <= itlfa_pkg::op_t'(in_op);
      hnd     <= in_handle;
      cnt     <= start_in;
      lim     <= lim_in;
      bad     <= bad_in;
      p_valid <= 1'b0;
    end else if (cmd.step) begin
      p_valid <= issue;
      if (issue) begin
        cnt    <= cnt + 1'b1;
        p_idx  <= cnt[itlfa_pkg::ADDR_W-1:0];
        p_used <= used_map[cnt[itlfa_pkg::ADDR_W-1:0]];
      end
    end
  end

  // Handle memory: one read port feeding the scan, one write port for add.
  always_ff @(posedge clk) begin
    if (cmd.step && issue) begin
      rdata <= mem[cnt[itlfa_pkg::ADDR_W-1:0]];
    end
    if (cmd.commit && !bad && hit && op == itlfa_pkg::OP_ADD) begin
      mem[p_idx] <= hnd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_map <= '0;
    end else if (cmd.commit && !bad && hit) begin
      if (op == itlfa_pkg::OP_ADD) begin
        used_map[p_idx] <= 1'b1;
      end else if (op == itlfa_pkg::OP_REMOVE) begin
        used_map[p_idx] <= 1'b0;
      end
    end
  end

  // Result register decouples the scan from the downstream handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status <= res_status;
      out_index  <= res_index;
      out_handle <= res_handle;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {{(itlfa_pkg::DATA_W - itlfa_pkg::IDX_W - itlfa_pkg::HANDLE_W){1'b0}},
                     out_handle, out_index};

endmodule

/* sv/itlfa_ctrl.sv */
// Controller state machine: accepts a request, runs the scan and commits the result.
module itlfa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  itlfa_pkg::sts_t   sts,
  output itlfa_pkg::cmd_t   cmd
);

  itlfa_pkg::state_t state;
  itlfa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itlfa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      itlfa_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = itlfa_pkg::S_SCAN;
        end
      end
      itlfa_pkg::S_SCAN: begin
        if (sts.done && sts.slot_free) begin
          state_next = itlfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = itlfa_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      itlfa_pkg::S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      itlfa_pkg::S_SCAN: begin
        cmd.step   = !sts.done;
        cmd.commit = sts.done && sts.slot_free;
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/indexed_table_lowest_free_allocator_core.sv */
// Lowest-free index allocator table: top level joining controller and datapath.
// Rejected requests are answered without a scan; find reads its one entry, and a scan stops at its first hit.
// A scan reads one entry per cycle through the single read port of the handle memory,
// so add, remove and find-next read up to TABLE_DEPTH entries; one request at a time.
// A finished result waits in an output register while the next request is accepted.
// Synchronous reset empties the used map; the handle memory is not cleared.
module indexed_table_lowest_free_allocator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [itlfa_pkg::DATA_W-1:0]      s_tdata,   // handle [15:0], index [22:16]
  input  logic [itlfa_pkg::OP_W-1:0]        s_tuser,   // opcode
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [itlfa_pkg::DATA_W-1:0]      m_tdata,   // found_index [6:0], found_handle [22:7]
  output logic [itlfa_pkg::STATUS_W-1:0]    m_tuser    // status
);

  itlfa_pkg::cmd_t cmd;
  itlfa_pkg::sts_t sts;

  itlfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  itlfa_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_op     (s_tuser),
    .in_handle (s_tdata[itlfa_pkg::HANDLE_W-1:0]),
    .in_index  (s_tdata[itlfa_pkg::HANDLE_W +: itlfa_pkg::IDX_W]),
    .m_tready  (m_tready),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

/* tb/indexed_table_lowest_free_allocator_core_tb.sv */
// Self-checking testbench for the lowest-free index allocator table core.
`timescale 1ns / 1ps

module indexed_table_lowest_free_allocator_core_tb;
  import itlfa_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int          TAIL_CYCLES  = TABLE_DEPTH + 8;
  localparam int          MAX_PRINTED  = 50;
  localparam int          RANDOM_ROUNDS = 10;
  localparam int          ROUND_ITEMS   = 150;

  typedef struct packed {
    status_t                status;
    logic [IDX_W-1:0]       index;
    logic [HANDLE_W-1:0]    handle;
  } table_result_t;

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [DATA_W-1:0]     s_tdata  = '0;
  logic [OP_W-1:0]       s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [DATA_W-1:0]     m_tdata;
  logic [STATUS_W-1:0]   m_tuser;

  // Shadow copy of the table, updated as each request is accepted.
  logic                  slot_used   [TABLE_DEPTH];
  logic [HANDLE_W-1:0]   slot_handle [TABLE_DEPTH];

  table_result_t         pending_results [$];
  int unsigned           cycle_count    = 0;
  int                    mismatch_count = 0;
  bit                    idle_on        = 1'b1;

  indexed_table_lowest_free_allocator_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      slot_used[k]   = 1'b0;
      slot_handle[k] = '0;
    end
  end

  always @(posedge clk) begin
    m_tready <= !idle_on || ($urandom_range(0, 99) >= 7);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    end
  endtask

  function automatic table_result_t apply_table_op(op_t op, logic [HANDLE_W-1:0] h,
                                                   logic [IDX_W-1:0] idx);
    table_result_t r;
    bit            hit;
    int            k;
    r   = '{ST_NOT_FOUND, '0, '0};
    hit = 1'b0;
    case (op)
      OP_ADD, OP_REMOVE: begin
        if (h == '0) begin
          r.status = ST_NULL;
        end else begin
          if (op == OP_ADD) r.status = ST_FULL;
          for (k = 0; k < TABLE_DEPTH && !hit; k++) begin
            if ((op == OP_ADD) ? !slot_used[k] : (slot_used[k] && slot_handle[k] == h)) begin
              hit            = 1'b1;
              slot_used[k]   = (op == OP_ADD);
              slot_handle[k] = h;
              r              = '{ST_DONE, IDX_W'(k + 1), h};
            end
          end
        end
      end
      OP_FIND: begin
        if (idx >= 1 && idx <= TABLE_DEPTH && slot_used[idx - 1]) begin
          r = '{ST_DONE, idx, slot_handle[idx - 1]};
        end
      end
      default: begin
        // Find-next treats index 0 as the first entry.
        for (k = (idx == 0) ? 0 : int'(idx) - 1; k < TABLE_DEPTH && !hit; k++) begin
          if (slot_used[k]) begin
            hit = 1'b1;
            r   = '{ST_DONE, IDX_W'(k + 1), slot_handle[k]};
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic int table_fill();
    int n;
    n = 0;
    for (int k = 0; k < TABLE_DEPTH; k++) n += slot_used[k];
    return n;
  endfunction

  // Returns some handle that is currently stored; only called with a non-empty table.
  function automatic logic [HANDLE_W-1:0] pick_stored_handle();
    int start;
    start = $urandom_range(0, TABLE_DEPTH - 1);
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (slot_used[(start + k) % TABLE_DEPTH]) return slot_handle[(start + k) % TABLE_DEPTH];
    end
    return '0;
  endfunction

  // Small pool of handles so that duplicates turn up often.
  function automatic logic [HANDLE_W-1:0] random_handle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)  return '0;
    if (r < 30) return HANDLE_W'($urandom_range(1, 6));
    if (r < 34) return '1;
    return HANDLE_W'($urandom_range(1, 65535));
  endfunction

  function automatic logic [IDX_W-1:0] random_index();
    if ($urandom_range(0, 99) < 75) return IDX_W'($urandom_range(0, TABLE_DEPTH + 2));
    return IDX_W'($urandom_range(0, 127));
  endfunction

  task automatic send_request(op_t op, logic [HANDLE_W-1:0] h, logic [IDX_W-1:0] idx);
    table_result_t want;
    if (idle_on && $urandom_range(0, 99) < 7) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 40);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, idx, h};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = apply_table_op(op, h, idx);
    pending_results.push_back(want);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    table_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request waiting, status", m_tuser, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.status)
          report_mismatch("status", m_tuser, want.status);
        if (m_tdata[6:0] !== want.index)
          report_mismatch("found_index", m_tdata[6:0], want.index);
        if (m_tdata[22:7] !== want.handle)
          report_mismatch("found_handle", m_tdata[22:7], want.handle);
      end
    end
  end

  task automatic test_empty_table();
    send_request(OP_FIND, '0, 7'd0);
    send_request(OP_FIND, '0, 7'd1);
    send_request(OP_FIND, '1, 7'd64);
    send_request(OP_FIND, '0, 7'd127);
    send_request(OP_FIND_NEXT, '0, 7'd0);
    send_request(OP_FIND_NEXT, '0, 7'd65);
    send_request(OP_REMOVE, 16'h1234, 7'd0);
    send_request(OP_ADD, '0, 7'd1);
    send_request(OP_REMOVE, '0, 7'd1);
  endtask

  task automatic test_basic_ops();
    send_request(OP_ADD, 16'hFFFF, 7'd0);
    send_request(OP_ADD, 16'h0001, 7'd127);
    send_request(OP_ADD, 16'hFFFF, 7'd0);
    send_request(OP_ADD, 16'hA5A5, 7'd0);
    send_request(OP_FIND, '0, 7'd1);
    send_request(OP_FIND, '0, 7'd3);
    send_request(OP_FIND, '0, 7'd5);
    send_request(OP_FIND_NEXT, '0, 7'd0);
    send_request(OP_FIND_NEXT, '0, 7'd3);
    send_request(OP_FIND_NEXT, '0, 7'd5);
    // A duplicated handle leaves from its lowest index first.
    send_request(OP_REMOVE, 16'hFFFF, 7'd0);
    send_request(OP_FIND_NEXT, '0, 7'd1);
    send_request(OP_REMOVE, 16'hFFFF, 7'd0);
    send_request(OP_REMOVE, 16'hFFFF, 7'd0);
    send_request(OP_ADD, 16'h5A5A, 7'd0);
    send_request(OP_REMOVE, 16'h0001, 7'd0);
  endtask

  task automatic test_full_table();
    wait_for_results();
    idle_on = 1'b0;
    while (table_fill() < TABLE_DEPTH)
      send_request(OP_ADD, HANDLE_W'($urandom_range(1, 65535)), random_index());
    send_request(OP_ADD, 16'h0BAD, 7'd0);
    send_request(OP_ADD, '0, 7'd0);
    send_request(OP_FIND, '0, 7'd64);
    send_request(OP_FIND_NEXT, '0, 7'd64);
    send_request(OP_FIND, '0, 7'd65);
    send_request(OP_FIND_NEXT, '0, 7'd65);
    send_request(OP_FIND_NEXT, '0, 7'd127);
    idle_on = 1'b1;
    // Punch a hole near the top and refill it.
    send_request(OP_REMOVE, slot_handle[TABLE_DEPTH - 1], 7'd0);
    send_request(OP_ADD, 16'h7E57, 7'd0);
    while (table_fill() > 0) send_request(OP_REMOVE, pick_stored_handle(), random_index());
    send_request(OP_FIND_NEXT, '0, 7'd0);
  endtask

  task automatic test_random_traffic();
    int   add_pct;
    int   r;
    op_t  op;
    logic [HANDLE_W-1:0] h;
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      // The add share drifts per round so the table swings between empty and full.
      case ($urandom_range(0, 2))
        0:       add_pct = 20;
        1:       add_pct = 40;
        default: add_pct = 62;
      endcase
      for (int n = 0; n < ROUND_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < add_pct)           op = OP_ADD;
        else if (r < add_pct + 28) op = OP_REMOVE;
        else                       op = $urandom_range(0, 1) ? OP_FIND : OP_FIND_NEXT;
        if (op == OP_REMOVE && table_fill() > 0 && $urandom_range(0, 99) < 65)
          h = pick_stored_handle();
        else
          h = random_handle();
        send_request(op, h, random_index());
      end
      if ($urandom_range(0, 2) == 0) wait_for_results();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_basic_ops();
    test_full_table();
    test_random_traffic();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
